[src/bounded_list_deque_unit_macros.svh]
// ----------------------------------------------------------------------------
// Bounded list deque assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_LIST_DEQUE_UNIT_MACROS_SVH

// same-cycle implication
`define BLD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bld_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded list deque package
// Field widths, request and status codes, memory control bundle.
// ----------------------------------------------------------------------------
package bld_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int ITEM_W    = 32;
	localparam int REQ_W     = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 4;
	localparam int TOTAL_W   = 5;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 80;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_REMOVE     = 3'd4,
		REQ_FIND       = 3'd5,
		REQ_REVERSE    = 3'd6
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic rd_en;
		logic val_we;
		logic link_we;
	} mem_ctl_t;

endpackage

[src/bld_node_store.sv]
// ----------------------------------------------------------------------------
// Bounded list deque node store
// Value and link memories, one write port each, shared registered read.
// ----------------------------------------------------------------------------
module bld_node_store #(
	parameter int CAPACITY = bld_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  bld_pkg::mem_ctl_t                  ctl,
	input  logic [$clog2(CAPACITY)-1:0]        rd_addr,
	input  logic [$clog2(CAPACITY)-1:0]        val_waddr,
	input  logic [bld_pkg::ITEM_W-1:0]         val_wdata,
	input  logic [$clog2(CAPACITY)-1:0]        link_waddr,
	input  logic [$clog2(CAPACITY+1)-1:0]      link_wdata,
	output logic [bld_pkg::ITEM_W-1:0]         val_rdata,
	output logic [$clog2(CAPACITY+1)-1:0]      link_rdata
);
	import bld_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);

	logic [ITEM_W-1:0] val_mem [CAPACITY];
	logic [LW-1:0]     link_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		if (ctl.rd_en) begin
			val_rdata <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (ctl.rd_en) begin
			link_rdata <= link_mem[rd_addr];
		end
	end

endmodule

[src/bounded_list_deque_unit.sv]
// Push scans the free map one slot a cycle for the lowest free slot, then at the back of a
// non-empty list links the new node from the old tail. Pop front reads the head link and,
// if nodes remain, refetches the new head value; pop back, remove, find and reverse walk the
// list one node per cycle, and removing the head of a longer list refetches the head value; a
// refused request goes straight to the result. One request in flight; the next is accepted once the result issues.
// Reset (arst_n low, asynchronous) empties the list and frees all slots.
// ----------------------------------------------------------------------------
// Bounded list deque unit
// Singly linked deque of signed 32-bit values held in a node store memory.
// ----------------------------------------------------------------------------
`include "bounded_list_deque_unit_macros.svh"

module bounded_list_deque_unit #(
	parameter int CAPACITY = bld_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bld_pkg::S_TDATA_W-1:0] s_tdata,  // item_value[31:0]
	input  logic [bld_pkg::REQ_W-1:0]     s_tuser,  // req_type[2:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], found_position[5:2], entry_total[10:6], front_value[42:11],
	// back_value[74:43], zero fill [79:75]
	output logic [bld_pkg::M_TDATA_W-1:0] m_tdata
);
	import bld_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);
	localparam int PAD_W = M_TDATA_W - STATUS_W - POS_W - TOTAL_W - 2 * ITEM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_LINK,
		ST_WALK,
		ST_HVAL,
		ST_FIN
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [ITEM_W-1:0] val_q;
	status_t           status_q;
	logic [POS_W-1:0]  pos_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     tail_q;
	logic [LW-1:0]     count_q;
	logic [ITEM_W-1:0] head_val_q;
	logic [ITEM_W-1:0] tail_val_q;
	logic [CAPACITY-1:0] free_q;
	logic [IW-1:0]     alloc_q;
	logic [LW-1:0]     slot_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     prev_q;
	logic [ITEM_W-1:0] prev_val_q;
	logic [LW-1:0]     steps_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	mem_ctl_t          ctl;
	logic [IW-1:0]     rd_addr;
	logic [IW-1:0]     link_waddr;
	logic [LW-1:0]     link_wdata;
	logic [ITEM_W-1:0] val_rd;
	logic [LW-1:0]     link_rd;
	logic              hit;
	logic              link_nil;
	logic              accept;
	logic              out_free;
	logic [ITEM_W-1:0] front_out;
	logic [ITEM_W-1:0] back_out;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign hit       = (val_rd == val_q);
	assign link_nil  = (link_rd == NIL);
	assign out_free  = !m_tvalid_q || m_tready;
	assign front_out = (count_q == '0) ? '1 : head_val_q;
	assign back_out  = (count_q == '0) ? '1 : tail_val_q;

	bld_node_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.val_waddr (alloc_q),
		.val_wdata (val_q),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.val_rdata (val_rd),
		.link_rdata(link_rd)
	);

	always_comb begin
		ctl        = '0;
		rd_addr    = head_q[IW-1:0];
		link_waddr = alloc_q;
		link_wdata = NIL;
		case (state_q)
			ST_IDLE: begin
				ctl.rd_en = s_tvalid;
			end
			ST_ALLOC: begin
				if (free_q[alloc_q]) begin
					ctl.val_we  = 1'b1;
					ctl.link_we = 1'b1;
					link_wdata  = (req_q == REQ_PUSH_FRONT) ? head_q : NIL;
				end
			end
			ST_LINK: begin
				ctl.link_we = 1'b1;
				link_waddr  = tail_q[IW-1:0];
				link_wdata  = slot_q;
			end
			ST_WALK: begin
				rd_addr = link_rd[IW-1:0];
				case (req_q)
					REQ_POP_FRONT: begin
						ctl.rd_en = !link_nil;
					end
					REQ_POP_BACK: begin
						ctl.rd_en = !link_nil;
						if (link_nil && prev_q != NIL) begin
							ctl.link_we = 1'b1;
							link_waddr  = prev_q[IW-1:0];
						end
					end
					REQ_REMOVE, REQ_FIND: begin
						if (!hit) begin
							ctl.rd_en = !link_nil;
						end else if (req_q == REQ_REMOVE) begin
							if (prev_q == NIL) begin
								ctl.rd_en = !link_nil;
							end else begin
								ctl.link_we = 1'b1;
								link_waddr  = prev_q[IW-1:0];
								link_wdata  = link_rd;
							end
						end
					end
					REQ_REVERSE: begin
						ctl.rd_en   = !link_nil;
						ctl.link_we = 1'b1;
						link_waddr  = cur_q[IW-1:0];
						link_wdata  = prev_q;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			req_q      <= REQ_PUSH_BACK;
			val_q      <= '0;
			status_q   <= STAT_OK;
			pos_q      <= '0;
			head_q     <= NIL;
			tail_q     <= NIL;
			count_q    <= '0;
			head_val_q <= '0;
			tail_val_q <= '0;
			free_q     <= '1;
			alloc_q    <= '0;
			slot_q     <= '0;
			cur_q      <= NIL;
			prev_q     <= NIL;
			prev_val_q <= '0;
			steps_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q    <= req_t'(s_tuser);
						val_q    <= s_tdata[ITEM_W-1:0];
						status_q <= STAT_OK;
						pos_q    <= '0;
						alloc_q  <= '0;
						cur_q    <= head_q;
						prev_q   <= NIL;
						steps_q  <= '0;
						case (req_t'(s_tuser))
							REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
								if (count_q == NIL) begin
									status_q <= STAT_FULL;
									state_q  <= ST_FIN;
								end else begin
									state_q <= ST_ALLOC;
								end
							end
							REQ_POP_FRONT, REQ_POP_BACK, REQ_REVERSE: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
									state_q  <= ST_FIN;
								end else begin
									state_q <= ST_WALK;
								end
							end
							REQ_REMOVE, REQ_FIND: begin
								if (count_q == '0) begin
									status_q <= STAT_NOTFOUND;
									state_q  <= ST_FIN;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					if (free_q[alloc_q]) begin
						free_q[alloc_q] <= 1'b0;
						count_q         <= count_q + 1'b1;
						slot_q          <= LW'(alloc_q);
						if (count_q == '0) begin
							head_q     <= LW'(alloc_q);
							tail_q     <= LW'(alloc_q);
							head_val_q <= val_q;
							tail_val_q <= val_q;
							state_q    <= ST_FIN;
						end else if (req_q == REQ_PUSH_FRONT) begin
							head_q     <= LW'(alloc_q);
							head_val_q <= val_q;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_LINK;
						end
					end else begin
						alloc_q <= alloc_q + 1'b1;
					end
				end
				ST_LINK: begin
					tail_q     <= slot_q;
					tail_val_q <= val_q;
					state_q    <= ST_FIN;
				end
				ST_WALK: begin
					case (req_q)
						REQ_POP_FRONT: begin
							free_q[cur_q[IW-1:0]] <= 1'b1;
							count_q <= count_q - 1'b1;
							head_q  <= link_rd;
							if (link_nil) begin
								tail_q  <= NIL;
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_HVAL;
							end
						end
						REQ_POP_BACK: begin
							if (!link_nil) begin
								prev_q     <= cur_q;
								prev_val_q <= val_rd;
								cur_q      <= link_rd;
							end else begin
								free_q[cur_q[IW-1:0]] <= 1'b1;
								count_q <= count_q - 1'b1;
								if (prev_q == NIL) begin
									head_q <= NIL;
									tail_q <= NIL;
								end else begin
									tail_q     <= prev_q;
									tail_val_q <= prev_val_q;
								end
								state_q <= ST_FIN;
							end
						end
						REQ_REMOVE, REQ_FIND: begin
							if (hit) begin
								if (req_q == REQ_FIND) begin
									pos_q   <= POS_W'(steps_q);
									state_q <= ST_FIN;
								end else begin
									free_q[cur_q[IW-1:0]] <= 1'b1;
									count_q <= count_q - 1'b1;
									if (cur_q == tail_q) begin
										tail_q     <= prev_q;
										tail_val_q <= prev_val_q;
									end
									if (prev_q == NIL) begin
										head_q  <= link_rd;
										state_q <= link_nil ? ST_FIN : ST_HVAL;
									end else begin
										state_q <= ST_FIN;
									end
								end
							end else if (link_nil) begin
								status_q <= STAT_NOTFOUND;
								state_q  <= ST_FIN;
							end else begin
								prev_q     <= cur_q;
								prev_val_q <= val_rd;
								cur_q      <= link_rd;
								steps_q    <= steps_q + 1'b1;
							end
						end
						REQ_REVERSE: begin
							prev_q <= cur_q;
							cur_q  <= link_rd;
							if (link_nil) begin
								tail_q     <= head_q;
								head_q     <= cur_q;
								head_val_q <= tail_val_q;
								tail_val_q <= head_val_q;
								state_q    <= ST_FIN;
							end
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_HVAL: begin
					head_val_q <= val_rd;
					state_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {PAD_W'(0), back_out, front_out, TOTAL_W'(count_q),
							pos_q, status_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BLD_ASSERT_IMP(a_count_range, 1'b1, count_q <= NIL, "entry count above capacity")
	`BLD_ASSERT_IMP(a_free_balance, 1'b1, $countones(free_q) + int'(count_q) == CAPACITY, "free map and entry count disagree")
	`BLD_ASSERT_IMP(a_empty_ends, 1'b1, (count_q == '0) == (head_q == NIL) && (head_q == NIL) == (tail_q == NIL), "list ends disagree with entry count")
	`BLD_ASSERT_NXT(a_result_issue, state_q == ST_FIN && out_free, m_tvalid_q && state_q == ST_IDLE, "finished request did not issue a result")

endmodule
